/* rtl/core/crd_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// crd_pkg
// Types and constants for the CAN record deframer with extended-ID decode.
// ----------------------------------------------------------------------------
package crd_pkg;

  localparam int unsigned HEADER_BYTES = 13;
  localparam int unsigned STAMP_BYTES  = 8;
  localparam int unsigned MAX_PAYLOAD  = 64;

  typedef enum logic [1:0] {
    KIND_HEADER  = 2'd0,
    KIND_PAYLOAD = 2'd1,
    KIND_TOOLONG = 2'd2,
    KIND_TRUNC   = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    XFER_MESSAGE  = 2'd0,
    XFER_RESPONSE = 2'd1,
    XFER_REQUEST  = 2'd2
  } xfer_t;

  localparam logic [7:0] NODE_UNSET = 8'hFF;

  typedef struct packed {
    kind_t       kind;
    logic [63:0] stamp;
    logic [28:0] frame_id;
    logic [2:0]  priority_res;
    logic        svc_flag;
    logic        anon_flag;
    logic [1:0]  xfer_kind;
    logic [12:0] port_number;
    logic [6:0]  source_node;
    logic [7:0]  dest_node;
    logic [7:0]  data_byte;
    logic        last_of_record;
  } result_t;

endpackage
`default_nettype wire

/* rtl/core/can_record_deframer_id_decode_top.sv */
`default_nettype none
// A result is written into the result queue when its byte is accepted and reaches the output in order.
// Throughput: one byte per cycle while in_ready is high; a byte yields up to two
// results, queued in a four-entry result queue that drains one result per cycle while out_ready is high.
// in_ready drops while the queue holds three or more results.
// Reset (rst, synchronous) clears the deframer state and empties the queue.
// ----------------------------------------------------------------------------
// can_record_deframer_id_decode_top
// Splits a record byte stream into header and payload results and decodes
// the Cyphal fields of the 29-bit extended CAN identifier.
// ----------------------------------------------------------------------------
module can_record_deframer_id_decode_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output      logic        in_ready,
  input  wire logic [7:0]  stream_byte,
  input  wire logic        end_of_buffer,
  output      logic        out_valid,
  input  wire logic        out_ready,
  output      logic [1:0]  result_kind,
  output      logic [63:0] stamp,
  output      logic [28:0] frame_id,
  output      logic [2:0]  priority_res,
  output      logic        svc_flag,
  output      logic        anon_flag,
  output      logic [1:0]  xfer_kind,
  output      logic [12:0] port_number,
  output      logic [6:0]  source_node,
  output      logic [7:0]  dest_node,
  output      logic [7:0]  data_byte,
  output      logic        last_of_record
);
  import crd_pkg::*;

  localparam int unsigned QDEPTH = 4;

  // deframer state
  logic [3:0]  header_index, header_index_next;
  logic [63:0] stamp_shift, stamp_shift_next;
  logic [31:0] id_shift, id_shift_next;
  logic [6:0]  payload_left, payload_left_next;
  logic        in_payload, in_payload_next;
  logic        discarding, discarding_next;

  // result queue
  result_t     queue [QDEPTH];
  logic [1:0]  wr_ptr, rd_ptr;
  logic [2:0]  count;

  logic        accept, pop;
  logic [1:0]  push_cnt;
  result_t     res0, res1, hdr_res, trunc_res;
  logic [6:0]  left_dec;
  logic [28:0] id29;
  logic        go_idle;

  assign accept   = in_valid && in_ready;
  assign pop      = out_valid && out_ready;
  assign in_ready = (count <= 3'd2);
  assign out_valid = (count != 3'd0);

  assign left_dec = payload_left - 7'd1;
  assign id29     = id_shift[28:0];

  always_comb begin
    trunc_res      = '0;
    trunc_res.kind = KIND_TRUNC;
  end

  // Header decode from the assembled identifier
  always_comb begin
    hdr_res              = '0;
    hdr_res.kind         = KIND_HEADER;
    hdr_res.stamp        = stamp_shift;
    hdr_res.frame_id     = id29;
    hdr_res.priority_res = id29[28:26];
    hdr_res.svc_flag     = id29[25];
    hdr_res.source_node  = id29[6:0];
    hdr_res.data_byte    = stream_byte;
    hdr_res.last_of_record = (stream_byte == 8'd0);
    if (!id29[25]) begin
      hdr_res.anon_flag   = id29[24];
      hdr_res.xfer_kind   = XFER_MESSAGE;
      hdr_res.port_number = id29[20:8];
      hdr_res.dest_node   = NODE_UNSET;
    end else begin
      hdr_res.anon_flag   = 1'b0;
      hdr_res.xfer_kind   = id29[24] ? XFER_REQUEST : XFER_RESPONSE;
      hdr_res.port_number = {3'd0, id29[23:14]};
      hdr_res.dest_node   = {1'b0, id29[13:7]};
    end
  end

  always_comb begin
    header_index_next = header_index;
    stamp_shift_next  = stamp_shift;
    id_shift_next     = id_shift;
    payload_left_next = payload_left;
    in_payload_next   = in_payload;
    discarding_next   = discarding;
    res0              = trunc_res;
    res1              = trunc_res;
    push_cnt          = 2'd0;
    go_idle           = 1'b0;

    if (accept) begin
      if (discarding) begin
        go_idle = end_of_buffer;
      end else if (in_payload) begin
        res0                = '0;
        res0.kind           = KIND_PAYLOAD;
        res0.data_byte      = stream_byte;
        res0.last_of_record = (left_dec == 7'd0);
        push_cnt            = 2'd1;
        if (left_dec == 7'd0) begin
          go_idle = 1'b1;
        end else if (end_of_buffer) begin
          push_cnt = 2'd2;
          go_idle  = 1'b1;
        end else begin
          payload_left_next = left_dec;
        end
      end else if (header_index == 4'(HEADER_BYTES - 1)) begin
        // length byte
        if (stream_byte > 8'(MAX_PAYLOAD)) begin
          res0           = '0;
          res0.kind      = KIND_TOOLONG;
          res0.data_byte = stream_byte;
          push_cnt       = 2'd1;
          go_idle        = 1'b1;
        end else begin
          res0     = hdr_res;
          push_cnt = 2'd1;
          if (stream_byte == 8'd0) begin
            go_idle = 1'b1;
          end else if (end_of_buffer) begin
            push_cnt = 2'd2;
            go_idle  = 1'b1;
          end else begin
            in_payload_next   = 1'b1;
            payload_left_next = stream_byte[6:0];
            header_index_next = 4'd0;
          end
        end
      end else begin
        if (header_index < 4'(STAMP_BYTES))
          stamp_shift_next = {stamp_shift[55:0], stream_byte};
        else
          id_shift_next = {id_shift[23:0], stream_byte};
        header_index_next = header_index + 4'd1;
        if (end_of_buffer) begin
          push_cnt = 2'd1;
          go_idle  = 1'b1;
        end
      end

      if (go_idle) begin
        header_index_next = '0;
        stamp_shift_next  = '0;
        id_shift_next     = '0;
        payload_left_next = '0;
        in_payload_next   = 1'b0;
        discarding_next   = 1'b0;
      end
      // an oversized length drops the rest of the buffer
      if (!discarding && !in_payload && header_index == 4'(HEADER_BYTES - 1) &&
          stream_byte > 8'(MAX_PAYLOAD) && !end_of_buffer)
        discarding_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      header_index <= '0;
      stamp_shift  <= '0;
      id_shift     <= '0;
      payload_left <= '0;
      in_payload   <= 1'b0;
      discarding   <= 1'b0;
      wr_ptr       <= '0;
      rd_ptr       <= '0;
      count        <= '0;
    end else begin
      header_index <= header_index_next;
      stamp_shift  <= stamp_shift_next;
      id_shift     <= id_shift_next;
      payload_left <= payload_left_next;
      in_payload   <= in_payload_next;
      discarding   <= discarding_next;
      wr_ptr       <= wr_ptr + push_cnt;
      if (pop)
        rd_ptr <= rd_ptr + 2'd1;
      count <= count + {1'b0, push_cnt} - {2'd0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push_cnt != 2'd0)
      queue[wr_ptr] <= res0;
    if (push_cnt == 2'd2)
      queue[wr_ptr + 2'd1] <= res1;
  end

  result_t head;
  assign head = queue[rd_ptr];

  assign result_kind    = head.kind;
  assign stamp          = head.stamp;
  assign frame_id       = head.frame_id;
  assign priority_res   = head.priority_res;
  assign svc_flag       = head.svc_flag;
  assign anon_flag      = head.anon_flag;
  assign xfer_kind      = head.xfer_kind;
  assign port_number    = head.port_number;
  assign source_node    = head.source_node;
  assign dest_node      = head.dest_node;
  assign data_byte      = head.data_byte;
  assign last_of_record = head.last_of_record;

endmodule
`default_nettype wire

/* dv/crd_checker.sv */
// ----------------------------------------------------------------------------
// crd_checker
// Watches both channels of the CAN record deframer. Every accepted byte runs
// through a local deframer/ID decoder whose results are queued, and each
// accepted result is compared field by field against the oldest queued one.
// ----------------------------------------------------------------------------
module crd_checker (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  input  wire logic        in_ready,
  input  wire logic [7:0]  stream_byte,
  input  wire logic        end_of_buffer,
  input  wire logic        out_valid,
  input  wire logic        out_ready,
  input  wire logic [1:0]  result_kind,
  input  wire logic [63:0] stamp,
  input  wire logic [28:0] frame_id,
  input  wire logic [2:0]  priority_res,
  input  wire logic        svc_flag,
  input  wire logic        anon_flag,
  input  wire logic [1:0]  xfer_kind,
  input  wire logic [12:0] port_number,
  input  wire logic [6:0]  source_node,
  input  wire logic [7:0]  dest_node,
  input  wire logic [7:0]  data_byte,
  input  wire logic        last_of_record,
  output int               fail_count,
  output int               pending
);
  import crd_pkg::*;

  // decoder state
  logic [3:0]  hdr_count;
  logic [63:0] stamp_acc;
  logic [31:0] id_acc;
  logic [6:0]  bytes_left;
  logic        payload_phase;
  logic        dropping;

  result_t want_q[$];
  int      errors = 0;

  task clear_state();
    hdr_count     = '0;
    stamp_acc     = '0;
    id_acc        = '0;
    bytes_left    = '0;
    payload_phase = 1'b0;
    dropping      = 1'b0;
  endtask

  task automatic want_add(result_t r);
    want_q.insert(want_q.size(), r);
  endtask

  function automatic result_t plain_result(kind_t k, logic [7:0] d, logic l);
    result_t r;
    r = '0;
    r.kind = k;
    r.data_byte = d;
    r.last_of_record = l;
    return r;
  endfunction

  function automatic result_t header_result(logic [7:0] len);
    logic [28:0] id;
    result_t     r;
    id = id_acc[28:0];
    r = '0;
    r.kind         = KIND_HEADER;
    r.stamp        = stamp_acc;
    r.frame_id     = id;
    r.priority_res = id[28:26];
    r.svc_flag     = id[25];
    r.source_node  = id[6:0];
    if (!id[25]) begin
      r.anon_flag   = id[24];
      r.xfer_kind   = XFER_MESSAGE;
      r.port_number = id[20:8];
      r.dest_node   = NODE_UNSET;
    end else begin
      r.xfer_kind   = id[24] ? XFER_REQUEST : XFER_RESPONSE;
      r.port_number = {3'b000, id[23:14]};
      r.dest_node   = {1'b0, id[13:7]};
    end
    r.data_byte      = len;
    r.last_of_record = (len == 8'd0);
    return r;
  endfunction

  task decode_byte(logic [7:0] b, logic eob);
    if (dropping) begin
      if (eob) clear_state();
    end else if (payload_phase) begin
      bytes_left = bytes_left - 7'd1;
      want_add(plain_result(KIND_PAYLOAD, b, bytes_left == 7'd0));
      if (bytes_left == 7'd0) begin
        clear_state();
      end else if (eob) begin
        want_add(plain_result(KIND_TRUNC, 8'd0, 1'b0));
        clear_state();
      end
    end else if (hdr_count < HEADER_BYTES - 1) begin
      if (hdr_count < STAMP_BYTES) stamp_acc = {stamp_acc[55:0], b};
      else id_acc = {id_acc[23:0], b};
      hdr_count = hdr_count + 4'd1;
      if (eob) begin
        want_add(plain_result(KIND_TRUNC, 8'd0, 1'b0));
        clear_state();
      end
    end else if (b > MAX_PAYLOAD) begin
      want_add(plain_result(KIND_TOOLONG, b, 1'b0));
      clear_state();
      // drop the rest of the buffer unless this byte already ended it
      dropping = !eob;
    end else begin
      want_add(header_result(b));
      if (b == 8'd0) begin
        clear_state();
      end else if (eob) begin
        want_add(plain_result(KIND_TRUNC, 8'd0, 1'b0));
        clear_state();
      end else begin
        payload_phase = 1'b1;
        bytes_left    = b[6:0];
        hdr_count     = '0;
      end
    end
  endtask

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected 0x%0h actual 0x%0h", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      clear_state();
      want_q.delete();
    end else begin
      if (in_valid && in_ready) decode_byte(stream_byte, end_of_buffer);
      if (out_valid && out_ready) begin
        if (want_q.size() == 0) begin
          $display("%0t: unexpected result: expected none actual kind %0d data 0x%0h",
                   $time, result_kind, data_byte);
          errors++;
        end else begin
          want = want_q.pop_front();
          check_field("result_kind", want.kind, result_kind);
          check_field("stamp", want.stamp, stamp);
          check_field("frame_id", want.frame_id, frame_id);
          check_field("priority_res", want.priority_res, priority_res);
          check_field("svc_flag", want.svc_flag, svc_flag);
          check_field("anon_flag", want.anon_flag, anon_flag);
          check_field("xfer_kind", want.xfer_kind, xfer_kind);
          check_field("port_number", want.port_number, port_number);
          check_field("source_node", want.source_node, source_node);
          check_field("dest_node", want.dest_node, dest_node);
          check_field("data_byte", want.data_byte, data_byte);
          check_field("last_of_record", want.last_of_record, last_of_record);
        end
      end
    end
    pending    <= want_q.size();
    fail_count <= errors;
  end

endmodule

/* dv/tb_can_record_deframer_id_decode_top.sv */
// ----------------------------------------------------------------------------
// tb_can_record_deframer_id_decode_top
// Feeds record buffers (well-formed, truncated, oversized length, noise) into
// the deframer with random gaps and output stalls; the checker predicts and
// compares every result transaction.
// ----------------------------------------------------------------------------
module tb_can_record_deframer_id_decode_top;
  import crd_pkg::*;

  localparam int IDLE_PCT    = 17;
  localparam int HOLD_CYCLES = 200;
  localparam int MAX_CYCLES  = 200000;
  localparam int ITEM_GOAL   = 650;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  stream_byte = '0;
  logic        end_of_buffer = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  result_kind;
  logic [63:0] stamp;
  logic [28:0] frame_id;
  logic [2:0]  priority_res;
  logic        svc_flag;
  logic        anon_flag;
  logic [1:0]  xfer_kind;
  logic [12:0] port_number;
  logic [6:0]  source_node;
  logic [7:0]  dest_node;
  logic [7:0]  data_byte;
  logic        last_of_record;

  int  fail_count;
  int  pending;
  int  cycles = 0;
  int  sent_bytes = 0;
  bit  calm = 1'b0;
  bit  hold_out = 1'b0;

  // {end_of_buffer, byte} of the buffer under construction
  logic [8:0] stream_q[$];

  always #1 clk = ~clk;

  can_record_deframer_id_decode_top dut (
    .clk, .rst, .in_valid, .in_ready, .stream_byte, .end_of_buffer,
    .out_valid, .out_ready, .result_kind, .stamp, .frame_id, .priority_res,
    .svc_flag, .anon_flag, .xfer_kind, .port_number, .source_node,
    .dest_node, .data_byte, .last_of_record
  );

  crd_checker checker_i (
    .clk, .rst, .in_valid, .in_ready, .stream_byte, .end_of_buffer,
    .out_valid, .out_ready, .result_kind, .stamp, .frame_id, .priority_res,
    .svc_flag, .anon_flag, .xfer_kind, .port_number, .source_node,
    .dest_node, .data_byte, .last_of_record,
    .fail_count(fail_count), .pending(pending)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > MAX_CYCLES) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // result side: random stalls, plus one long hold-off on request
  initial begin
    forever begin
      if (hold_out) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_out = 1'b0;
      end else begin
        out_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
        @(posedge clk);
      end
    end
  end

  task send_byte(logic [7:0] b, logic eob);
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    stream_byte   <= b;
    end_of_buffer <= eob;
    do @(posedge clk); while (!in_ready);
    sent_bytes++;
  endtask

  task add_entry(logic [8:0] e);
    stream_q.insert(stream_q.size(), e);
  endtask

  // header plus payload; an oversized length gets no payload bytes
  task push_record(logic [63:0] st, logic [31:0] id, logic [7:0] len);
    for (int i = 7; i >= 0; i--) add_entry({1'b0, st[i*8 +: 8]});
    for (int i = 3; i >= 0; i--) add_entry({1'b0, id[i*8 +: 8]});
    add_entry({1'b0, len});
    if (len <= MAX_PAYLOAD)
      for (int j = 0; j < len; j++) add_entry({1'b0, 8'($urandom)});
  endtask

  task close_buffer();
    stream_q[stream_q.size() - 1][8] = 1'b1;
  endtask

  task cut_and_close(int keep);
    while (stream_q.size() > keep) void'(stream_q.pop_back());
    close_buffer();
  endtask

  task add_noise(int n);
    repeat (n) add_entry({1'b0, 8'($urandom)});
  endtask

  task flush_buffer();
    logic [8:0] e;
    while (stream_q.size() > 0) begin
      e = stream_q.pop_front();
      send_byte(e[7:0], e[8]);
    end
  endtask

  task wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  function automatic logic [7:0] pick_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 8'($urandom_range(0, 6));
    if (r < 90) return 8'($urandom_range(7, 63));
    return 8'(MAX_PAYLOAD);
  endfunction

  initial begin
    int nbuf;
    int r;
    int keep;

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // service request with all-ones fields, zero length
    push_record(64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 8'd0);
    close_buffer();
    flush_buffer();
    // all-zero message, one payload byte
    push_record(64'd0, 32'd0, 8'd1);
    close_buffer();
    flush_buffer();
    // anonymous message then a full-size service response in one buffer
    push_record(64'h0123_4567_89AB_CDEF, 32'h0100_AB05, 8'd2);
    push_record(64'hFEDC_BA98_7654_3210, 32'h1200_3F81, 8'(MAX_PAYLOAD));
    close_buffer();
    flush_buffer();
    // length just over the limit, then dropped bytes up to buffer end
    push_record(64'h55, 32'h0C00_0001, 8'(MAX_PAYLOAD + 1));
    add_noise(3);
    close_buffer();
    flush_buffer();
    // oversized length on the final byte of the buffer
    push_record(64'hAA, 32'h1E00_0000, 8'hFF);
    close_buffer();
    flush_buffer();
    // truncation inside header, on the length byte, inside payload
    push_record(64'h1, 32'h2, 8'd5);
    cut_and_close(6);
    flush_buffer();
    push_record(64'h3, 32'h0300_4000, 8'd3);
    cut_and_close(13);
    flush_buffer();
    push_record(64'h4, 32'h0000_1F7F, 8'd4);
    cut_and_close(15);
    flush_buffer();
    wait_drained();

    nbuf = 0;
    while (sent_bytes < ITEM_GOAL) begin
      nbuf++;
      calm = (nbuf >= 3 && nbuf < 6);
      r = $urandom_range(0, 99);
      if (nbuf == 2) begin
        // long receiver stall while a full-size payload keeps streaming in
        hold_out = 1'b1;
        push_record({$urandom, $urandom}, $urandom, 8'(MAX_PAYLOAD));
        close_buffer();
      end else if (r < 72) begin
        repeat ($urandom_range(1, 3)) push_record({$urandom, $urandom}, $urandom, pick_len());
        close_buffer();
      end else if (r < 84) begin
        repeat ($urandom_range(1, 2)) push_record({$urandom, $urandom}, $urandom, pick_len());
        keep = $urandom_range(1, stream_q.size() - 1);
        cut_and_close(keep);
      end else if (r < 93) begin
        push_record({$urandom, $urandom}, $urandom, 8'($urandom_range(MAX_PAYLOAD + 1, 255)));
        add_noise($urandom_range(0, 6));
        close_buffer();
      end else begin
        add_noise($urandom_range(1, 12));
        close_buffer();
      end
      flush_buffer();
      if (nbuf == 6) wait_drained();
    end

    calm = 1'b0;
    wait_drained();
    repeat (8) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

/* can_record_deframer_id_decode_top.f */
rtl/core/crd_pkg.sv
rtl/core/can_record_deframer_id_decode_top.sv
dv/crd_checker.sv
dv/tb_can_record_deframer_id_decode_top.sv
